[rtl/arta_pkg.sv]
// Shared types, widths and codes for the address region table allocator.
// No dependencies; used by every file in rtl/.
package arta_pkg;

    localparam int ADDR_W   = 64;
    localparam int LEN_W    = 48;
    localparam int FLAG_W   = 16;
    localparam int PAGES_W  = 36;
    localparam int HIDX_W   = 6;
    localparam int STAT_W   = 3;

    localparam int MAX_REGIONS_DEF = 64;
    localparam int PAGE_BYTES_DEF  = 4096;

    localparam logic [1:0] OP_CREATE  = 2'd0;
    localparam logic [1:0] OP_DESTROY = 2'd1;
    localparam logic [1:0] OP_ALLOC   = 2'd2;
    localparam logic [1:0] OP_LOOKUP  = 2'd3;

    localparam logic [STAT_W-1:0] ST_OK    = 3'd0;
    localparam logic [STAT_W-1:0] ST_NONE  = 3'd1;
    localparam logic [STAT_W-1:0] ST_USER  = 3'd2;
    localparam logic [STAT_W-1:0] ST_FULL  = 3'd3;
    localparam logic [STAT_W-1:0] ST_INDEX = 3'd4;

    localparam logic CFG_WSTART = 1'b0;
    localparam logic CFG_WEND   = 1'b1;

    typedef struct packed {
        logic [ADDR_W-1:0] base;
        logic [LEN_W-1:0]  len;
        logic [FLAG_W-1:0] flags;
    } entry_t;

endpackage

[rtl/arta_cell.sv]
// One table entry in the rotating chain of cells.
// Depends on arta_pkg (entry_t).
module arta_cell
(
    input  logic            clk,
    input  logic            shift_en,
    input  arta_pkg::entry_t d,
    output arta_pkg::entry_t q
);

    arta_pkg::entry_t q_reg;

    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            q_reg <= d;
        end
    end

    assign q = q_reg;

endmodule

[rtl/address_region_table_allocator_top.sv]
// Address region table allocator: controller and ring of arta_cell entries.
// Depends on arta_pkg and arta_cell.
//
// Usage:
//   Input channel (in_valid/in_ready) takes one operation beat: create, destroy,
//   allocate or fault lookup. Output channel (out_valid/out_ready) returns one
//   result beat per operation. cfg_write/cfg_index/cfg_data set window_start (0)
//   and window_end (1); the user must write them only while the block is idle,
//   which the block itself does not enforce. The table lives in a ring of
//   MAX_REGIONS cells that rotates one entry per cycle, only during a pass; the
//   controller sees the head entry and its successor each cycle.
//   Create, destroy and lookup take one rotation, or none when rejected (table
//   full, bad index, user fault). Allocate takes a search rotation, a decide step
//   and, unless rejected there, an edit rotation. One operation is in flight at
//   a time. A new beat is taken once the result sits in the output register, even
//   while the receiver stalls; a finished result waits until that register frees.
//   Reset empties the table and sets the window to the whole address space.
module address_region_table_allocator_top
#(
    parameter int MAX_REGIONS = arta_pkg::MAX_REGIONS_DEF,
    parameter int PAGE_BYTES  = arta_pkg::PAGE_BYTES_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [1:0]                    operation,
    input  logic [arta_pkg::ADDR_W-1:0]   address,
    input  logic [arta_pkg::LEN_W-1:0]    length,
    input  logic [arta_pkg::PAGES_W-1:0]  page_count,
    input  logic [arta_pkg::FLAG_W-1:0]   region_flags_in,
    input  logic [arta_pkg::HIDX_W-1:0]   remove_index,
    input  logic                          fault_user,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [arta_pkg::STAT_W-1:0]   status,
    output logic [arta_pkg::ADDR_W-1:0]   result_address,
    output logic [arta_pkg::HIDX_W-1:0]   hit_index,
    output logic [arta_pkg::FLAG_W-1:0]   hit_flags,
    input  logic                          cfg_write,
    input  logic                          cfg_index,
    input  logic [arta_pkg::ADDR_W-1:0]   cfg_data
);

    localparam int IW    = $clog2(MAX_REGIONS);
    localparam int CW    = $clog2(MAX_REGIONS + 1);
    localparam int CMPW  = (CW > arta_pkg::HIDX_W) ? CW : arta_pkg::HIDX_W;
    localparam int PG_SH = $clog2(PAGE_BYTES);
    localparam int AW    = arta_pkg::ADDR_W;
    localparam int LW    = arta_pkg::LEN_W;
    localparam int FW    = arta_pkg::FLAG_W;
    localparam logic [IW-1:0] J_LAST = IW'(MAX_REGIONS - 1);
    localparam logic [CW-1:0] CNT_MAX = CW'(MAX_REGIONS);

    typedef enum logic [1:0] {S_IDLE, S_PASS, S_DECIDE, S_DONE} state_t;
    typedef enum logic [1:0] {PK_EDIT, PK_LOOK, PK_SCAN} pass_t;

    arta_pkg::entry_t ring_q [MAX_REGIONS];
    arta_pkg::entry_t feed;
    arta_pkg::entry_t head;
    arta_pkg::entry_t tap;
    logic             shift_en;

    state_t           state_reg;
    pass_t            kind_reg;
    logic [IW-1:0]    j_reg;
    logic [CW-1:0]    count_reg;
    logic [AW-1:0]    ws_reg;
    logic [AW-1:0]    we_reg;
    logic             ins_en_reg;
    logic             rm_en_reg;
    logic             mod_en_reg;
    logic [IW-1:0]    mod_idx_reg;
    logic [IW-1:0]    rm_idx_reg;
    arta_pkg::entry_t new_reg;
    arta_pkg::entry_t carry_reg;
    arta_pkg::entry_t carry_next;
    logic             done_reg;
    logic             done_next;
    logic             found_reg;
    logic             stop_reg;
    logic [AW-1:0]    key_reg;
    logic [AW-1:0]    size_reg;
    logic [FW-1:0]    fl_reg;
    logic [IW-1:0]    a_i_reg;
    logic [AW-1:0]    a_base_reg;
    logic [AW-1:0]    a_pend_reg;
    logic [LW-1:0]    a_len_i_reg;
    logic [LW-1:0]    a_len_n_reg;
    logic             a_fm_i_reg;
    logic             a_fm_n_reg;
    logic             a_touch_reg;

    logic [arta_pkg::STAT_W-1:0] res_status_reg;
    logic [AW-1:0]               res_addr_reg;
    logic [IW-1:0]               res_idx_reg;
    logic [FW-1:0]               res_flags_reg;

    logic                        out_valid_reg;
    logic [arta_pkg::STAT_W-1:0] status_reg;
    logic [AW-1:0]               result_address_reg;
    logic [arta_pkg::HIDX_W-1:0] hit_index_reg;
    logic [FW-1:0]               hit_flags_reg;

    // ring
    assign shift_en = (state_reg == S_PASS);
    assign head     = ring_q[MAX_REGIONS-1];
    assign tap      = ring_q[MAX_REGIONS-2];

    for (genvar k = 0; k < MAX_REGIONS; k++)
    begin : g_cell
        if (k == 0)
        begin : g_first
            arta_cell u_cell (.clk(clk), .shift_en(shift_en), .d(feed), .q(ring_q[k]));
        end
        else
        begin : g_rest
            arta_cell u_cell (.clk(clk), .shift_en(shift_en), .d(ring_q[k-1]), .q(ring_q[k]));
        end
    end

    // per-cycle views of the head entry
    logic [CW-1:0] jx;
    logic          in_rng;
    logic          next_rng;
    logic [AW:0]   sum_e;
    logic          e_c;
    logic [AW-1:0] pend;
    logic [AW:0]   gap_end;
    logic          skip;
    logic          fit;
    logic          brk;
    logic          hit;
    logic          ins_here;

    assign jx       = CW'(j_reg);
    assign in_rng   = jx < count_reg;
    assign next_rng = ({1'b0, jx} + {{CW{1'b0}}, 1'b1}) < {1'b0, count_reg};
    assign sum_e    = {1'b0, head.base} + (AW+1)'(head.len);
    assign e_c      = sum_e[AW];
    assign pend     = sum_e[AW-1:0];
    assign gap_end  = {1'b0, pend} + {1'b0, size_reg};
    assign skip     = !e_c && (pend < ws_reg);
    assign fit      = !e_c && !gap_end[AW] && (gap_end[AW-1:0] <= tap.base);
    assign brk      = head.base >= we_reg;
    assign hit      = (head.base <= key_reg) && (e_c || (key_reg < pend));
    assign ins_here = !in_rng || (head.base >= new_reg.base);

    always_comb
    begin
        feed       = head;
        carry_next = carry_reg;
        done_next  = done_reg;
        if (kind_reg == PK_EDIT)
        begin
            if (ins_en_reg)
            begin
                if (done_reg)
                begin
                    feed       = carry_reg;
                    carry_next = head;
                end
                else if (ins_here)
                begin
                    feed       = new_reg;
                    carry_next = head;
                    done_next  = 1'b1;
                end
            end
            else
            begin
                if (rm_en_reg && (j_reg >= rm_idx_reg))
                begin
                    feed = tap;
                end
                if (mod_en_reg && (j_reg == mod_idx_reg))
                begin
                    feed.base = new_reg.base;
                    feed.len  = new_reg.len;
                end
            end
        end
    end

    // allocation decision arithmetic
    logic [AW:0] grown;
    logic [AW:0] rgrow;
    logic [AW:0] merged;
    logic        ovf_grown;
    logic        ovf_rgrow;
    logic        ovf_merged;

    assign grown      = (AW+1)'(a_len_i_reg) + {1'b0, size_reg};
    assign rgrow      = (AW+1)'(a_len_n_reg) + {1'b0, size_reg};
    assign merged     = grown + (AW+1)'(a_len_n_reg);
    assign ovf_grown  = |grown[AW:LW];
    assign ovf_rgrow  = |rgrow[AW:LW];
    assign ovf_merged = |merged[AW:LW];

    logic [CMPW-1:0] ri_ext;
    logic [IW+arta_pkg::HIDX_W-1:0] idx_wide;
    logic            out_free;

    assign ri_ext   = CMPW'(remove_index);
    assign idx_wide = {{arta_pkg::HIDX_W{1'b0}}, res_idx_reg};
    assign out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= S_IDLE;
            kind_reg           <= PK_EDIT;
            j_reg              <= '0;
            count_reg          <= '0;
            ws_reg             <= '0;
            we_reg             <= '1;
            ins_en_reg         <= 1'b0;
            rm_en_reg          <= 1'b0;
            mod_en_reg         <= 1'b0;
            mod_idx_reg        <= '0;
            rm_idx_reg         <= '0;
            new_reg            <= '0;
            carry_reg          <= '0;
            done_reg           <= 1'b0;
            found_reg          <= 1'b0;
            stop_reg           <= 1'b0;
            key_reg            <= '0;
            size_reg           <= '0;
            fl_reg             <= '0;
            a_i_reg            <= '0;
            a_base_reg         <= '0;
            a_pend_reg         <= '0;
            a_len_i_reg        <= '0;
            a_len_n_reg        <= '0;
            a_fm_i_reg         <= 1'b0;
            a_fm_n_reg         <= 1'b0;
            a_touch_reg        <= 1'b0;
            res_status_reg     <= arta_pkg::ST_OK;
            res_addr_reg       <= '0;
            res_idx_reg        <= '0;
            res_flags_reg      <= '0;
            out_valid_reg      <= 1'b0;
            status_reg         <= arta_pkg::ST_OK;
            result_address_reg <= '0;
            hit_index_reg      <= '0;
            hit_flags_reg      <= '0;
        end
        else
        begin
            // in S_DONE the output register is reloaded below
            if (out_valid_reg && out_ready && (state_reg != S_DONE))
            begin
                out_valid_reg <= 1'b0;
            end

            if (cfg_write)
            begin
                unique case (cfg_index)
                    arta_pkg::CFG_WSTART: ws_reg <= cfg_data;
                    arta_pkg::CFG_WEND:   we_reg <= cfg_data;
                    default:              ws_reg <= ws_reg;
                endcase
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        j_reg          <= '0;
                        done_reg       <= 1'b0;
                        found_reg      <= 1'b0;
                        stop_reg       <= 1'b0;
                        ins_en_reg     <= (operation == arta_pkg::OP_CREATE);
                        rm_en_reg      <= (operation == arta_pkg::OP_DESTROY);
                        mod_en_reg     <= 1'b0;
                        res_addr_reg   <= (operation == arta_pkg::OP_CREATE) ? address : '0;
                        res_idx_reg    <= (operation == arta_pkg::OP_DESTROY) ?
                                          ri_ext[IW-1:0] : '0;
                        res_flags_reg  <= (operation == arta_pkg::OP_CREATE) ?
                                          region_flags_in : '0;
                        fl_reg         <= region_flags_in;
                        key_reg        <= address;
                        size_reg       <= AW'(page_count) << PG_SH;
                        unique case (operation)
                            arta_pkg::OP_CREATE:
                            begin
                                if (count_reg >= CNT_MAX)
                                begin
                                    res_status_reg <= arta_pkg::ST_FULL;
                                    state_reg      <= S_DONE;
                                end
                                else
                                begin
                                    kind_reg       <= PK_EDIT;
                                    new_reg        <= '{address, length, region_flags_in};
                                    res_status_reg <= arta_pkg::ST_OK;
                                    state_reg      <= S_PASS;
                                end
                            end
                            arta_pkg::OP_DESTROY:
                            begin
                                if (ri_ext >= CMPW'(count_reg))
                                begin
                                    res_status_reg <= arta_pkg::ST_INDEX;
                                    state_reg      <= S_DONE;
                                end
                                else
                                begin
                                    kind_reg       <= PK_EDIT;
                                    rm_idx_reg     <= ri_ext[IW-1:0];
                                    res_status_reg <= arta_pkg::ST_OK;
                                    state_reg      <= S_PASS;
                                end
                            end
                            arta_pkg::OP_ALLOC:
                            begin
                                kind_reg       <= PK_SCAN;
                                res_status_reg <= arta_pkg::ST_OK;
                                state_reg      <= S_PASS;
                            end
                            arta_pkg::OP_LOOKUP:
                            begin
                                if (fault_user)
                                begin
                                    res_status_reg <= arta_pkg::ST_USER;
                                    state_reg      <= S_DONE;
                                end
                                else
                                begin
                                    kind_reg       <= PK_LOOK;
                                    res_status_reg <= arta_pkg::ST_NONE;
                                    state_reg      <= S_PASS;
                                end
                            end
                            default:
                            begin
                                state_reg <= S_IDLE;
                            end
                        endcase
                    end
                end

                S_PASS:
                begin
                    carry_reg <= carry_next;
                    done_reg  <= done_next;

                    unique case (kind_reg)
                        PK_EDIT:
                        begin
                            if (ins_en_reg && !done_reg && ins_here)
                            begin
                                res_idx_reg <= j_reg;
                            end
                            if (rm_en_reg && !mod_en_reg && (j_reg == rm_idx_reg))
                            begin
                                res_addr_reg  <= head.base;
                                res_flags_reg <= head.flags;
                            end
                        end
                        PK_LOOK:
                        begin
                            if (!found_reg && in_rng && hit)
                            begin
                                found_reg      <= 1'b1;
                                res_status_reg <= arta_pkg::ST_OK;
                                res_addr_reg   <= head.base;
                                res_idx_reg    <= j_reg;
                                res_flags_reg  <= head.flags;
                            end
                        end
                        PK_SCAN:
                        begin
                            if (!found_reg && !stop_reg && next_rng && !skip)
                            begin
                                if (fit)
                                begin
                                    found_reg   <= 1'b1;
                                    a_i_reg     <= j_reg;
                                    a_base_reg  <= head.base;
                                    a_pend_reg  <= pend;
                                    a_len_i_reg <= head.len;
                                    a_len_n_reg <= tap.len;
                                    a_fm_i_reg  <= (head.flags == fl_reg);
                                    a_fm_n_reg  <= (tap.flags == fl_reg);
                                    a_touch_reg <= (gap_end[AW-1:0] == tap.base);
                                end
                                else if (brk)
                                begin
                                    stop_reg <= 1'b1;
                                end
                            end
                        end
                        default:
                        begin
                            stop_reg <= stop_reg;
                        end
                    endcase

                    if (j_reg == J_LAST)
                    begin
                        j_reg <= '0;
                        if (kind_reg == PK_EDIT)
                        begin
                            if (ins_en_reg)
                            begin
                                count_reg <= count_reg + CW'(1);
                            end
                            else if (rm_en_reg)
                            begin
                                count_reg <= count_reg - CW'(1);
                            end
                        end
                        state_reg <= (kind_reg == PK_SCAN) ? S_DECIDE : S_DONE;
                    end
                    else
                    begin
                        j_reg <= j_reg + IW'(1);
                    end
                end

                S_DECIDE:
                begin
                    kind_reg      <= PK_EDIT;
                    done_reg      <= 1'b0;
                    res_addr_reg  <= a_pend_reg;
                    res_flags_reg <= fl_reg;
                    priority if (!found_reg)
                    begin
                        res_status_reg <= arta_pkg::ST_NONE;
                        state_reg      <= S_DONE;
                    end
                    else if (a_fm_i_reg)
                    begin
                        if (ovf_grown || (a_touch_reg && a_fm_n_reg && ovf_merged))
                        begin
                            res_status_reg <= arta_pkg::ST_NONE;
                            state_reg      <= S_DONE;
                        end
                        else if (a_touch_reg && a_fm_n_reg)
                        begin
                            mod_en_reg  <= 1'b1;
                            mod_idx_reg <= a_i_reg;
                            res_idx_reg <= a_i_reg;
                            new_reg     <= '{a_base_reg, merged[LW-1:0], fl_reg};
                            rm_en_reg   <= 1'b1;
                            rm_idx_reg  <= a_i_reg + IW'(1);
                            state_reg   <= S_PASS;
                        end
                        else
                        begin
                            mod_en_reg  <= 1'b1;
                            mod_idx_reg <= a_i_reg;
                            res_idx_reg <= a_i_reg;
                            new_reg     <= '{a_base_reg, grown[LW-1:0], fl_reg};
                            state_reg   <= S_PASS;
                        end
                    end
                    else if (a_touch_reg && a_fm_n_reg)
                    begin
                        if (ovf_rgrow)
                        begin
                            res_status_reg <= arta_pkg::ST_NONE;
                            state_reg      <= S_DONE;
                        end
                        else
                        begin
                            mod_en_reg  <= 1'b1;
                            mod_idx_reg <= a_i_reg + IW'(1);
                            res_idx_reg <= a_i_reg + IW'(1);
                            new_reg     <= '{a_pend_reg, rgrow[LW-1:0], fl_reg};
                            state_reg   <= S_PASS;
                        end
                    end
                    else if (|size_reg[AW-1:LW])
                    begin
                        res_status_reg <= arta_pkg::ST_NONE;
                        state_reg      <= S_DONE;
                    end
                    else if (count_reg >= CNT_MAX)
                    begin
                        res_status_reg <= arta_pkg::ST_FULL;
                        state_reg      <= S_DONE;
                    end
                    else
                    begin
                        ins_en_reg <= 1'b1;
                        new_reg    <= '{a_pend_reg, size_reg[LW-1:0], fl_reg};
                        state_reg  <= S_PASS;
                    end
                end

                S_DONE:
                begin
                    if (out_free)
                    begin
                        out_valid_reg  <= 1'b1;
                        status_reg     <= res_status_reg;
                        if (res_status_reg == arta_pkg::ST_OK)
                        begin
                            result_address_reg <= res_addr_reg;
                            hit_index_reg      <= idx_wide[arta_pkg::HIDX_W-1:0];
                            hit_flags_reg      <= res_flags_reg;
                        end
                        else
                        begin
                            result_address_reg <= '0;
                            hit_index_reg      <= '0;
                            hit_flags_reg      <= '0;
                        end
                        state_reg <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign in_ready       = (state_reg == S_IDLE);
    assign out_valid      = out_valid_reg;
    assign status         = status_reg;
    assign result_address = result_address_reg;
    assign hit_index      = hit_index_reg;
    assign hit_flags      = hit_flags_reg;

endmodule
